// ===== design/ffrc_pkg.sv =====
// shared constants, codes and helper functions for the float/fixed ring codec
package ffrc_pkg;

   localparam int RING_BITS_DEFAULT = 64;
   localparam int FRAC_W            = 6;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 6'd18;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [3:0] PT_BOOL = 4'd0;
   localparam logic [3:0] PT_I8   = 4'd1;
   localparam logic [3:0] PT_U8   = 4'd2;
   localparam logic [3:0] PT_I16  = 4'd3;
   localparam logic [3:0] PT_U16  = 4'd4;
   localparam logic [3:0] PT_I32  = 4'd5;
   localparam logic [3:0] PT_U32  = 4'd6;
   localparam logic [3:0] PT_I64  = 4'd7;
   localparam logic [3:0] PT_U64  = 4'd8;
   localparam logic [3:0] PT_F32  = 4'd9;
   localparam logic [3:0] PT_F64  = 4'd10;

   localparam logic [1:0] RK_BOOL  = 2'd0;
   localparam logic [1:0] RK_FIXED = 2'd1;
   localparam logic [1:0] RK_INT   = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  plain_type;
      logic [1:0]  ring_kind;
      logic [63:0] raw_value;
   } req_type;

   // truncate to the plain type, bool type reports nonzero
   function automatic logic [63:0] int_out(input logic [3:0] t, input logic [63:0] v);
      logic [63:0] r;
      case (t) inside
         PT_BOOL:        r = {63'd0, |v};
         PT_I8, PT_U8:   r = {56'd0, v[7:0]};
         PT_I16, PT_U16: r = {48'd0, v[15:0]};
         PT_I32, PT_U32: r = {32'd0, v[31:0]};
         default:        r = v;
      endcase
      return r;
   endfunction

   // position of the highest set bit, zero when none
   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

endpackage

// ===== design/ffrc_ifs.sv =====
// request and response channel interfaces
interface ffrc_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [3:0]  plain_type;
   logic [1:0]  ring_kind;
   logic [63:0] raw_value;
   modport source (output valid, opcode, plain_type, ring_kind, raw_value, input ready);
   modport sink   (input valid, opcode, plain_type, ring_kind, raw_value, output ready);
endinterface

interface ffrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_value;
   logic        bad_request;
   modport source (output valid, result_value, bad_request, input ready);
   modport sink   (input valid, result_value, bad_request, output ready);
endinterface

// ===== design/ffrc_enc.sv =====
// encoder: plaintext to ring word
module ffrc_enc #(
   parameter int RING_BITS = ffrc_pkg::RING_BITS_DEFAULT
) (
   input  logic [3:0]                   plain_type,
   input  logic [63:0]                  raw_value,
   input  logic [ffrc_pkg::FRAC_W-1:0]  frac_bits,
   output logic [63:0]                  ring_word
);
   localparam logic [63:0] RING_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - RING_BITS);
   localparam logic [63:0] SAT_POS   = (64'd1 << (RING_BITS - 2)) - 64'd1;
   localparam logic [63:0] SAT_NEG   = (64'd0 - (64'd1 << (RING_BITS - 2))) & RING_MASK;
   localparam logic signed [12:0] SAT_EXP = 13'(RING_BITS - 2);

   logic              sgn, is_nan, is_inf, is_zsub;
   logic [52:0]       mant;
   logic signed [12:0] k;
   logic [63:0]       mag, fval, ival;

   always_comb begin
      if (plain_type == ffrc_pkg::PT_F32) begin
         sgn     = raw_value[31];
         is_nan  = (&raw_value[30:23]) && (|raw_value[22:0]);
         is_inf  = (&raw_value[30:23]) && !(|raw_value[22:0]);
         is_zsub = raw_value[30:23] == 8'd0;
         mant    = {1'b1, raw_value[22:0], 29'd0};
         k       = $signed({5'd0, raw_value[30:23]}) - 13'sd127
                   + $signed({7'd0, frac_bits});
      end else begin
         sgn     = raw_value[63];
         is_nan  = (&raw_value[62:52]) && (|raw_value[51:0]);
         is_inf  = (&raw_value[62:52]) && !(|raw_value[51:0]);
         is_zsub = raw_value[62:52] == 11'd0;
         mant    = {1'b1, raw_value[51:0]};
         k       = $signed({2'd0, raw_value[62:52]}) - 13'sd1023
                   + $signed({7'd0, frac_bits});
      end
      // integer part of the scaled magnitude
      if (k < 0) mag = '0;
      else if (k <= 13'sd52) mag = {11'd0, mant} >> 6'(13'sd52 - k);
      else mag = {11'd0, mant} << 6'(k - 13'sd52);

      // subnormals scale below one and truncate to zero
      if (is_nan || is_zsub) fval = '0;
      else if (is_inf || k >= SAT_EXP) fval = sgn ? SAT_NEG : SAT_POS;
      else fval = (sgn ? (64'd0 - mag) : mag) & RING_MASK;

      case (plain_type)
         ffrc_pkg::PT_BOOL: ival = {63'd0, raw_value[0]};
         ffrc_pkg::PT_I8:   ival = {{56{raw_value[7]}}, raw_value[7:0]};
         ffrc_pkg::PT_U8:   ival = {56'd0, raw_value[7:0]};
         ffrc_pkg::PT_I16:  ival = {{48{raw_value[15]}}, raw_value[15:0]};
         ffrc_pkg::PT_U16:  ival = {48'd0, raw_value[15:0]};
         ffrc_pkg::PT_I32:  ival = {{32{raw_value[31]}}, raw_value[31:0]};
         ffrc_pkg::PT_U32:  ival = {32'd0, raw_value[31:0]};
         default:           ival = raw_value;
      endcase

      if (plain_type == ffrc_pkg::PT_F32 || plain_type == ffrc_pkg::PT_F64) ring_word = fval;
      else ring_word = ival & RING_MASK;
   end
endmodule

// ===== design/ffrc_dec.sv =====
// decoder: ring word to plaintext
module ffrc_dec #(
   parameter int RING_BITS = ffrc_pkg::RING_BITS_DEFAULT
) (
   input  logic [3:0]                   plain_type,
   input  logic [1:0]                   ring_kind,
   input  logic [63:0]                  raw_value,
   input  logic [ffrc_pkg::FRAC_W-1:0]  frac_bits,
   output logic [63:0]                  plain_value,
   output logic                         bad_request
);
   localparam int SH = 64 - RING_BITS;

   logic [63:0] w, mag, norm, fxi, fval;
   logic        neg, is_flt, up;
   logic [5:0]  p, sh;
   logic [53:0] r64;
   logic [24:0] r32;
   logic [10:0] e64;
   logic [7:0]  e32;

   always_comb begin
      w      = 64'($signed(raw_value << SH) >>> SH);
      neg    = w[63];
      mag    = neg ? (64'd0 - w) : w;
      is_flt = plain_type == ffrc_pkg::PT_F32 || plain_type == ffrc_pkg::PT_F64;
      sh     = (ring_kind == ffrc_pkg::RK_FIXED) ? frac_bits : 6'd0;

      // normalize then round to nearest even
      p    = ffrc_pkg::msb_pos(mag);
      norm = mag << (6'd63 - p);
      up   = norm[10] && ((|norm[9:0]) || norm[11]);
      r64  = {1'b0, norm[63:11]} + {53'd0, up};
      e64  = 11'd1023 + {5'd0, p} - {5'd0, sh} + {10'd0, r64[53]};
      up   = norm[39] && ((|norm[38:0]) || norm[40]);
      r32  = {1'b0, norm[63:40]} + {24'd0, up};
      e32  = 8'd127 + {2'd0, p} - {2'd0, sh} + {7'd0, r32[24]};

      if (mag == 64'd0) fval = '0;
      else if (plain_type == ffrc_pkg::PT_F32)
         fval = {32'd0, neg, e32, r32[24] ? 23'd0 : r32[22:0]};
      else
         fval = {neg, e64, r64[53] ? 52'd0 : r64[51:0]};

      fxi = mag >> frac_bits;
      fxi = neg ? (64'd0 - fxi) : fxi;

      bad_request = 1'b0;
      case (ring_kind)
         ffrc_pkg::RK_BOOL: begin
            if (plain_type == ffrc_pkg::PT_BOOL) plain_value = {63'd0, w[0]};
            else begin
               plain_value = '0;
               bad_request = 1'b1;
            end
         end
         ffrc_pkg::RK_FIXED: plain_value = is_flt ? fval : ffrc_pkg::int_out(plain_type, fxi);
         default:            plain_value = is_flt ? fval : ffrc_pkg::int_out(plain_type, w);
      endcase
   end
endmodule

// ===== design/float_fixed_ring_codec.sv =====
// float/fixed ring codec: converts plaintext elements to and from ring words
//
// requests arrive on req_chan (opcode, plain_type, ring_kind, raw_value);
// one response per request leaves on rsp_chan (result_value, bad_request),
// in request order. a transfer happens when valid and ready are both high.
// csr_wr_en/csr_wr_data write frac_bits; write it only while no request is
// in flight.
// a request is registered in the input register; its result is then
// registered in the output register, which drives response valid.
// throughput: one request per cycle unless the receiver stalls, set by
// the single input and output registers with all conversion logic between.
// reset (synchronous) empties both registers and sets frac_bits to 18.
// when the receiver stalls, the response holds and the input register
// keeps one more request; req_chan.ready drops once both are full.
module float_fixed_ring_codec #(
   parameter int RING_BITS = ffrc_pkg::RING_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   ffrc_req_if.sink                     req_chan,
   ffrc_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [ffrc_pkg::FRAC_W-1:0]  csr_wr_data
);
   logic [ffrc_pkg::FRAC_W-1:0] frac_ff;
   ffrc_pkg::req_type req_ff;
   logic        req_v_ff, rsp_v_ff, bad_ff, bad_in, stall;
   logic [63:0] res_ff, res_in, enc_word, dec_word;

   assign stall          = rsp_v_ff && !rsp_chan.ready;
   assign req_chan.ready = !(req_v_ff && stall);

   ffrc_enc #(.RING_BITS(RING_BITS)) u_enc (
      .plain_type (req_ff.plain_type),
      .raw_value  (req_ff.raw_value),
      .frac_bits  (frac_ff),
      .ring_word  (enc_word)
   );

   ffrc_dec #(.RING_BITS(RING_BITS)) u_dec (
      .plain_type  (req_ff.plain_type),
      .ring_kind   (req_ff.ring_kind),
      .raw_value   (req_ff.raw_value),
      .frac_bits   (frac_ff),
      .plain_value (dec_word),
      .bad_request (bad_in)
   );

   assign res_in = (req_ff.opcode == ffrc_pkg::OP_DECODE) ? dec_word : enc_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff  <= ffrc_pkg::FRAC_RESET;
         req_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) frac_ff <= csr_wr_data;
         if (req_chan.ready) req_v_ff <= req_chan.valid;
         if (!stall) rsp_v_ff <= req_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         req_ff.opcode     <= req_chan.opcode;
         req_ff.plain_type <= req_chan.plain_type;
         req_ff.ring_kind  <= req_chan.ring_kind;
         req_ff.raw_value  <= req_chan.raw_value;
      end
      if (!stall) begin
         res_ff <= res_in;
         bad_ff <= (req_ff.opcode == ffrc_pkg::OP_DECODE) && bad_in;
      end
   end

   assign rsp_chan.valid        = rsp_v_ff;
   assign rsp_chan.result_value = res_ff;
   assign rsp_chan.bad_request  = bad_ff;
endmodule

// ===== design/ffrc_checker.sv =====
// port-level checker for the ring codec, bound to the top level
module ffrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result_value,
   input logic        rsp_bad_request
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_bad_request))
      else $error("response payload changed while stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("response missing two cycles after transfer");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_request |-> rsp_result_value == 64'd0)
      else $error("bad request with nonzero result");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind float_fixed_ring_codec ffrc_checker u_ffrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_result_value (rsp_chan.result_value),
   .rsp_bad_request  (rsp_chan.bad_request)
);

// ===== tb/sv/tb_float_fixed_ring_codec.sv =====
// testbench for the float/fixed ring codec: directed table, then random items checked by a predictor
`timescale 1ns / 100ps

module tb_float_fixed_ring_codec;

   typedef struct {
      logic        opcode;
      logic [3:0]  plain_type;
      logic [1:0]  ring_kind;
      logic [63:0] raw_value;
      bit          typed;
      logic [63:0] want_value;
      logic        want_bad;
   } stim_row_type;

   typedef struct {
      logic [63:0] result_value;
      logic        bad_request;
   } codec_out_type;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 100;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ffrc_pkg::FRAC_W-1:0] csr_wr_data;

   ffrc_req_if req_if ();
   ffrc_rsp_if rsp_if ();

   float_fixed_ring_codec dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   codec_out_type expected_q[$];
   int unsigned frac_model;
   int errors;
   bit no_idle;
   bit hold_req;
   int stall_cycles;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // highest set bit, -1 when zero
   function automatic int top_bit(logic [63:0] v);
      int p;
      p = -1;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = i;
      end
      return p;
   endfunction

   function automatic int width_of(logic [3:0] t);
      case (t) inside
         ffrc_pkg::PT_BOOL:                  return 1;
         ffrc_pkg::PT_I8, ffrc_pkg::PT_U8:   return 8;
         ffrc_pkg::PT_I16, ffrc_pkg::PT_U16: return 16;
         ffrc_pkg::PT_I32, ffrc_pkg::PT_U32: return 32;
         default:                            return 64;
      endcase
   endfunction

   function automatic logic [63:0] truncate_to_type(logic [3:0] t, logic [63:0] w);
      int wd;
      wd = width_of(t);
      if (t == ffrc_pkg::PT_BOOL) return {63'd0, |w};
      if (wd >= 64) return w;
      return w & ((64'd1 << wd) - 1);
   endfunction

   // float fields to scaled fixed point, truncated toward zero, saturating
   function automatic logic [63:0] float_to_fixed(logic sgn, int e_field, logic [63:0] frac,
                                                  int e_ones, int bias, int mbits, int fb);
      logic [63:0] m;
      logic [63:0] mag;
      int e;
      int sh;
      if (e_field == e_ones) begin
         if (frac != 0) return 64'd0;
         return sgn ? 64'hC000_0000_0000_0000 : 64'h3FFF_FFFF_FFFF_FFFF;
      end
      if (e_field == 0) begin
         m = frac;
         e = 1 - bias;
      end else begin
         m = frac | (64'd1 << mbits);
         e = e_field - bias;
      end
      if (m == 0) return 64'd0;
      if (top_bit(m) + e - mbits >= 62 - fb)
         return sgn ? 64'hC000_0000_0000_0000 : 64'h3FFF_FFFF_FFFF_FFFF;
      sh = e - mbits + fb;
      if (sh >= 0) mag = m << sh;
      else if (-sh >= 64) mag = 64'd0;
      else mag = m >> (-sh);
      return sgn ? -mag : mag;
   endfunction

   // signed word over 2^shift, rounded to nearest even, as f32 or f64 bits
   function automatic logic [63:0] word_to_float_bits(logic [63:0] w, bit single, int shift);
      logic neg;
      logic [63:0] mag;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] qn;
      int s;
      int len;
      int mant;
      int p;
      int e;
      int mb;
      neg = w[63];
      mag = neg ? -w : w;
      if (mag == 0) return 64'd0;
      mant = single ? 24 : 53;
      mb = mant - 1;
      len = top_bit(mag) + 1;
      s = 0;
      q = mag;
      if (len > mant) begin
         s = len - mant;
         q = mag >> s;
         rem = mag & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && q[0])) q = q + 1;
      end
      p = top_bit(q);
      e = p + s - shift;
      qn = (p <= mb) ? (q << (mb - p)) : (q >> (p - mb));
      if (single) return {32'd0, neg, 8'(e + 127), qn[22:0]};
      return {neg, 11'(e + 1023), qn[51:0]};
   endfunction

   function automatic codec_out_type predict_codec(logic op, logic [3:0] t, logic [1:0] kind,
                                                   logic [63:0] raw, int fb);
      codec_out_type r;
      logic [63:0] v;
      logic [63:0] mag;
      int wd;
      bit is_float;
      r.result_value = 64'd0;
      r.bad_request = 1'b0;
      is_float = (t == ffrc_pkg::PT_F32 || t == ffrc_pkg::PT_F64);
      if (op == ffrc_pkg::OP_ENCODE) begin
         if (t == ffrc_pkg::PT_F32)
            r.result_value = float_to_fixed(raw[31], int'(raw[30:23]), {41'd0, raw[22:0]},
                                            255, 127, 23, fb);
         else if (t == ffrc_pkg::PT_F64)
            r.result_value = float_to_fixed(raw[63], int'(raw[62:52]), {12'd0, raw[51:0]},
                                            2047, 1023, 52, fb);
         else if (t == ffrc_pkg::PT_BOOL)
            r.result_value = {63'd0, raw[0]};
         else begin
            wd = width_of(t);
            v = (wd >= 64) ? raw : raw & ((64'd1 << wd) - 1);
            if ((t == ffrc_pkg::PT_I8 || t == ffrc_pkg::PT_I16 || t == ffrc_pkg::PT_I32)
                && v[wd-1])
               v = v | (~64'd0 << wd);
            r.result_value = v;
         end
      end else if (kind == ffrc_pkg::RK_BOOL) begin
         if (t == ffrc_pkg::PT_BOOL) r.result_value = {63'd0, raw[0]};
         else r.bad_request = 1'b1;
      end else if (kind == ffrc_pkg::RK_FIXED) begin
         if (is_float)
            r.result_value = word_to_float_bits(raw, t == ffrc_pkg::PT_F32, fb);
         else begin
            mag = raw[63] ? -raw : raw;
            mag = mag >> fb;
            r.result_value = truncate_to_type(t, raw[63] ? -mag : mag);
         end
      end else begin
         r.result_value = is_float ? word_to_float_bits(raw, t == ffrc_pkg::PT_F32, 0)
                                   : truncate_to_type(t, raw);
      end
      return r;
   endfunction

   function automatic stim_row_type row(logic op, logic [3:0] t, logic [1:0] kind,
                                        logic [63:0] raw, bit typed = 1'b0,
                                        logic [63:0] wv = '0, logic wb = 1'b0);
      stim_row_type s;
      s.opcode = op;
      s.plain_type = t;
      s.ring_kind = kind;
      s.raw_value = raw;
      s.typed = typed;
      s.want_value = wv;
      s.want_bad = wb;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(stim_row_type s);
      int gap;
      codec_out_type p;
      gap = no_idle ? 0 : int'($urandom_range(0, 5));
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.opcode = s.opcode;
      req_if.plain_type = s.plain_type;
      req_if.ring_kind = s.ring_kind;
      req_if.raw_value = s.raw_value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (s.typed) begin
         p.result_value = s.want_value;
         p.bad_request = s.want_bad;
      end else
         p = predict_codec(s.opcode, s.plain_type, s.ring_kind, s.raw_value, frac_model);
      expected_q.push_back(p);
      @(negedge clock);
   endtask

   task automatic set_frac_bits(int unsigned fb);
      req_if.valid = 1'b0;
      while (expected_q.size() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = ffrc_pkg::FRAC_W'(fb);
      @(negedge clock);
      csr_wr_en = 1'b0;
      frac_model = fb;
   endtask

   function automatic stim_row_type random_item();
      stim_row_type s;
      int pick;
      s = row(1'($urandom_range(0, 1)),
              ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10)),
              2'($urandom_range(0, 3)), {$urandom, $urandom});
      pick = $urandom_range(0, 9);
      if (s.opcode == ffrc_pkg::OP_ENCODE && s.plain_type == ffrc_pkg::PT_F64) begin
         if (pick == 0) s.raw_value[62:52] = 11'h7FF;
         else if (pick == 1) s.raw_value[62:52] = 11'h000;
         else if (pick == 2) s.raw_value[62:0] = 63'd0;
         else s.raw_value[62:52] = 11'(1023 + $urandom_range(0, 160) - 80);
      end else if (s.opcode == ffrc_pkg::OP_ENCODE && s.plain_type == ffrc_pkg::PT_F32) begin
         if (pick == 0) s.raw_value[30:23] = 8'hFF;
         else if (pick == 1) s.raw_value[30:23] = 8'h00;
         else if (pick == 2) s.raw_value[30:0] = 31'd0;
         else s.raw_value[30:23] = 8'(127 + $urandom_range(0, 110) - 40);
      end else if (s.opcode == ffrc_pkg::OP_DECODE && pick < 5) begin
         // small signed words so fixed decode lands in a useful range
         s.raw_value = {{44{s.raw_value[19]}}, s.raw_value[19:0]} << $urandom_range(0, 40);
      end else if (pick == 9) begin
         s.raw_value = {64{s.raw_value[0]}};
      end
      return s;
   endfunction

   // response side: random stalls, one long hold-off on request, checking
   initial begin
      codec_out_type want;
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_if.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_req = 1'b0;
         end
         gap = no_idle ? 0 : int'($urandom_range(0, 5));
         if (gap > 0) begin
            rsp_if.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         if (expected_q.size() == 0)
            report_mismatch("unexpected transfer", rsp_if.result_value, 64'd0);
         else begin
            want = expected_q.pop_front();
            if (rsp_if.result_value !== want.result_value)
               report_mismatch("result_value", rsp_if.result_value, want.result_value);
            if (rsp_if.bad_request !== want.bad_request)
               report_mismatch("bad_request", {63'd0, rsp_if.bad_request},
                               {63'd0, want.bad_request});
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      stim_row_type dir_tab[$];
      int unsigned fb_list[6];
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.opcode = ffrc_pkg::OP_ENCODE;
      req_if.plain_type = ffrc_pkg::PT_BOOL;
      req_if.ring_kind = ffrc_pkg::RK_BOOL;
      req_if.raw_value = '0;
      errors = 0;
      no_idle = 0;
      hold_req = 0;
      frac_model = 18;

      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_BOOL, ffrc_pkg::RK_BOOL,
                            64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'd0));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_BOOL, ffrc_pkg::RK_BOOL,
                            64'd1, 1'b1, 64'd1));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_I8, ffrc_pkg::RK_BOOL,
                            64'h80, 1'b1, 64'hFFFF_FFFF_FFFF_FF80));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_U8, ffrc_pkg::RK_BOOL,
                            64'hFFFF, 1'b1, 64'hFF));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_I16, ffrc_pkg::RK_BOOL,
                            64'h7FFF, 1'b1, 64'h7FFF));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_U32, ffrc_pkg::RK_BOOL,
                            '1, 1'b1, 64'hFFFF_FFFF));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_I64, ffrc_pkg::RK_BOOL,
                            64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_BOOL,
                            64'h7FF0_0000_0000_0000, 1'b1, 64'h3FFF_FFFF_FFFF_FFFF));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_BOOL,
                            64'hFFF0_0000_0000_0000, 1'b1, 64'hC000_0000_0000_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_BOOL,
                            64'h7FF8_0000_0000_0000, 1'b1, 64'd0));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F32, ffrc_pkg::RK_BOOL,
                            64'h7FC0_0000, 1'b1, 64'd0));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_BOOL,
                            64'h3FF0_0000_0000_0000, 1'b1, 64'h4_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F32, ffrc_pkg::RK_INT,
                            64'hDEAD_BEEF_BFC0_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_BOOL,
                            64'h42B0_0000_0000_0000, 1'b1, 64'h3FFF_FFFF_FFFF_FFFF));
      dir_tab.push_back(row(ffrc_pkg::OP_ENCODE, 4'd13, ffrc_pkg::RK_BOOL,
                            64'h0123_4567_89AB_CDEF));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_I8, ffrc_pkg::RK_BOOL,
                            64'h55, 1'b1, 64'd0, 1'b1));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_BOOL, ffrc_pkg::RK_BOOL,
                            64'd3, 1'b1, 64'd1));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_FIXED,
                            64'h4_0000, 1'b1, 64'h3FF0_0000_0000_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_F32, ffrc_pkg::RK_FIXED, '1));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_I32, ffrc_pkg::RK_FIXED,
                            64'hFFFF_FFFF_FFF8_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_U16, ffrc_pkg::RK_INT,
                            64'h1_2345, 1'b1, 64'h2345));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_F64, ffrc_pkg::RK_INT,
                            '1, 1'b1, 64'hBFF0_0000_0000_0000));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_I8, 2'd3, 64'h1FF));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_BOOL, ffrc_pkg::RK_INT,
                            64'h100, 1'b1, 64'd1));
      dir_tab.push_back(row(ffrc_pkg::OP_DECODE, ffrc_pkg::PT_F32, ffrc_pkg::RK_INT,
                            64'h8000_0000_0000_0000));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) send_item(dir_tab[i]);

      fb_list = '{0, 62, 63, 18, 0, 0};
      fb_list[4] = $urandom_range(1, 61);
      fb_list[5] = $urandom_range(1, 61);
      foreach (fb_list[ph]) begin
         set_frac_bits(fb_list[ph]);
         for (int n = 0; n < 205; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
            // receiver holds off while the sender keeps offering transfers
            if (ph == 1 && n == 60) begin
               no_idle = 1;
               hold_req = 1;
            end
            send_item(random_item());
         end
      end
      req_if.valid = 1'b0;

      while (expected_q.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
design/ffrc_pkg.sv
design/ffrc_ifs.sv
design/ffrc_enc.sv
design/ffrc_dec.sv
design/float_fixed_ring_codec.sv
design/ffrc_checker.sv
tb/sv/tb_float_fixed_ring_codec.sv
